FILE: src/csi_pkg.sv
`default_nettype none

package csi_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_KIND  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_X       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_ONE_Y = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_TWO_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y         = 3'd6;

    typedef enum logic [1:0] {
        KIND_MOVE     = 2'd0,
        KIND_CONSTANT = 2'd1,
        KIND_LINE     = 2'd2,
        KIND_BEZIER   = 2'd3
    } kind_t;

    // what the output stage drives for a beat
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_START = 2'd1,
        RES_CALC  = 2'd2
    } res_sel_t;

    // where t comes from
    typedef enum logic [1:0] {
        T_ZERO = 2'd0,
        T_ONE  = 2'd1,
        T_DIV  = 2'd2
    } t_sel_t;

    typedef struct packed {
        logic     valid;
        res_sel_t sel;
        t_sel_t   tsel;
        logic     line;
        logic     clamped;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: src/curve_segment_interpolator.sv
`default_nettype none

// Curve segment interpolator.
// Configuration: write channel cfg_valid/cfg_ready with cfg_index and cfg_data.
// cfg_ready is always high; a register is written on every cfg_valid beat.
// Indexes: 0 segment_kind, 1 start_x, 2 start_y, 3 control_one_y,
// 4 control_two_y, 5 end_x, 6 end_y. Other indexes are ignored.
// Write configuration only while no sample is in flight.
// Samples: a beat is taken on each edge with start high and busy low.
// busy never rises, so one sample can enter every cycle.
// Results: done pulses for one cycle with sample_value and position_clamped.
// Each sample passes through the restoring divider for t (Q1.16 by default),
// one quotient bit per stage, and then the weight and blend multiplier
// stages.
// Throughput: one result per cycle, in order.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the configuration registers to zero and empties the pipeline;
// items in flight are dropped.
module curve_segment_interpolator #(
    parameter int FRACTION_BITS = csi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [csi_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                      cfg_data,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [31:0]                      sample_index,
    output logic                                  done,
    output logic signed [31:0]                    sample_value,
    output logic                                  position_clamped
);

    localparam int F    = FRACTION_BITS;
    localparam int TW   = F + 1;
    localparam int P2W  = 2 * F + 2;
    localparam int WW   = F + 2;
    localparam int PW   = 32 + WW + 1;
    localparam int AW   = PW + 2;
    localparam int RW   = AW - F;
    localparam int LAT  = F + 10;

    localparam logic [TW-1:0]  ONE_T  = {1'b1, {F{1'b0}}};
    localparam logic [P2W:0]   HALF_P = {{(P2W + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [AW-1:0]  HALF_A = {{(AW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

    // ---------------- configuration ----------------
    csi_pkg::kind_t     segment_kind_reg;
    logic [31:0]        start_x_reg;
    logic signed [31:0] start_y_reg;
    logic signed [31:0] control_one_y_reg;
    logic signed [31:0] control_two_y_reg;
    logic [31:0]        end_x_reg;
    logic signed [31:0] end_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_kind_reg  <= csi_pkg::KIND_MOVE;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            control_one_y_reg <= '0;
            control_two_y_reg <= '0;
            end_x_reg         <= '0;
            end_y_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csi_pkg::REG_SEGMENT_KIND:  segment_kind_reg  <= csi_pkg::kind_t'(cfg_data[1:0]);
                csi_pkg::REG_START_X:       start_x_reg       <= cfg_data;
                csi_pkg::REG_START_Y:       start_y_reg       <= $signed(cfg_data);
                csi_pkg::REG_CONTROL_ONE_Y: control_one_y_reg <= $signed(cfg_data);
                csi_pkg::REG_CONTROL_TWO_Y: control_two_y_reg <= $signed(cfg_data);
                csi_pkg::REG_END_X:         end_x_reg         <= cfg_data;
                csi_pkg::REG_END_Y:         end_y_reg         <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: differences ----------------
    logic               accept;
    csi_pkg::ctrl_t     c0_next;
    csi_pkg::ctrl_t     c0_reg;
    logic signed [32:0] d0_next;
    logic signed [32:0] sp0_next;
    logic signed [32:0] d0_reg;
    logic signed [32:0] sp0_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign d0_next  = $signed({1'b0, sample_index}) - $signed({1'b0, start_x_reg});
    assign sp0_next = $signed({1'b0, end_x_reg}) - $signed({1'b0, start_x_reg});

    always_comb
    begin
        c0_next         = '0;
        c0_next.valid   = accept;
        c0_next.tsel    = csi_pkg::T_ZERO;
        c0_next.line    = (segment_kind_reg == csi_pkg::KIND_LINE);
        c0_next.clamped = 1'b0;
        case (segment_kind_reg)
            csi_pkg::KIND_MOVE:     c0_next.sel = csi_pkg::RES_ZERO;
            csi_pkg::KIND_CONSTANT: c0_next.sel = csi_pkg::RES_START;
            default:
            begin
                if (end_x_reg == start_x_reg)
                    c0_next.sel = csi_pkg::RES_START;
                else
                    c0_next.sel = csi_pkg::RES_CALC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c0_reg <= '0;
        else
            c0_reg <= c0_next;
    end

    always_ff @(posedge clk)
    begin
        d0_reg  <= d0_next;
        sp0_reg <= sp0_next;
    end

    // ---------------- stage 1: clamp decision, magnitudes ----------------
    csi_pkg::ctrl_t cdv_reg   [0:F];
    logic [31:0]    rem_reg   [0:F];
    logic [31:0]    dspan_reg [0:F];
    logic [F-1:0]   q_reg     [0:F];

    csi_pkg::ctrl_t     c1_next;
    logic               sp_neg;
    logic               d_lt0;
    logic               d_gt0;
    logic               d_lt_sp;
    logic               d_gt_sp;
    logic               at_low;
    logic               below_low;
    logic               at_high;
    logic               above_high;
    logic signed [32:0] d_abs;
    logic signed [32:0] sp_abs;

    assign sp_neg  = sp0_reg[32];
    assign d_lt0   = d0_reg[32];
    assign d_gt0   = !d0_reg[32] && (|d0_reg);
    assign d_lt_sp = d0_reg < sp0_reg;
    assign d_gt_sp = sp0_reg < d0_reg;

    // with a negative span both differences flip sign
    assign at_low     = sp_neg ? !d_lt0   : !d_gt0;
    assign below_low  = sp_neg ? d_gt0    : d_lt0;
    assign at_high    = sp_neg ? !d_gt_sp : !d_lt_sp;
    assign above_high = sp_neg ? d_lt_sp  : d_gt_sp;

    assign d_abs  = sp_neg ? -d0_reg  : d0_reg;
    assign sp_abs = sp_neg ? -sp0_reg : sp0_reg;

    always_comb
    begin
        c1_next         = c0_reg;
        c1_next.clamped = 1'b0;
        if (at_low)
        begin
            c1_next.tsel = csi_pkg::T_ZERO;
            if (c0_reg.sel == csi_pkg::RES_CALC)
                c1_next.clamped = below_low;
        end
        else if (at_high)
        begin
            c1_next.tsel = csi_pkg::T_ONE;
            if (c0_reg.sel == csi_pkg::RES_CALC)
                c1_next.clamped = above_high;
        end
        else
        begin
            c1_next.tsel = csi_pkg::T_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cdv_reg[0] <= '0;
        else
            cdv_reg[0] <= c1_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]   <= d_abs[31:0];
        dspan_reg[0] <= sp_abs[31:0];
        q_reg[0]     <= '0;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < F; k++)
    begin : g_div
        logic [32:0] r2;
        logic [32:0] diff;
        logic        ge;

        assign r2   = {rem_reg[k], 1'b0};
        assign diff = r2 - {1'b0, dspan_reg[k]};
        assign ge   = (r2 >= {1'b0, dspan_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cdv_reg[k+1] <= '0;
            else
                cdv_reg[k+1] <= cdv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]   <= ge ? diff[31:0] : r2[31:0];
            dspan_reg[k+1] <= dspan_reg[k];
            q_reg[k+1]     <= {q_reg[k][F-2:0], ge};
        end
    end

    // ---------------- stage T: t and 1 - t ----------------
    csi_pkg::ctrl_t ct_reg;
    logic [TW-1:0]  t_next;
    logic [TW-1:0]  t_reg;
    logic [TW-1:0]  mt_reg;

    always_comb
    begin
        case (cdv_reg[F].tsel)
            csi_pkg::T_ZERO: t_next = '0;
            csi_pkg::T_ONE:  t_next = ONE_T;
            default:         t_next = {1'b0, q_reg[F]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ct_reg <= '0;
        else
            ct_reg <= cdv_reg[F];
    end

    always_ff @(posedge clk)
    begin
        t_reg  <= t_next;
        mt_reg <= ONE_T - t_next;
    end

    // ---------------- stage A: squares ----------------
    csi_pkg::ctrl_t ca_reg;
    logic [P2W-1:0] mtsq_reg;
    logic [P2W-1:0] tsq_reg;
    logic [TW-1:0]  t_a_reg;
    logic [TW-1:0]  mt_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ca_reg <= '0;
        else
            ca_reg <= ct_reg;
    end

    always_ff @(posedge clk)
    begin
        mtsq_reg <= mt_reg * mt_reg;
        tsq_reg  <= t_reg * t_reg;
        t_a_reg  <= t_reg;
        mt_a_reg <= mt_reg;
    end

    // ---------------- stage B: round squares ----------------
    csi_pkg::ctrl_t cb_reg;
    logic [P2W:0]   mt2_sum;
    logic [P2W:0]   t2_sum;
    logic [TW-1:0]  mt2_reg;
    logic [TW-1:0]  t2_reg;
    logic [TW-1:0]  t_b_reg;
    logic [TW-1:0]  mt_b_reg;

    assign mt2_sum = {1'b0, mtsq_reg} + HALF_P;
    assign t2_sum  = {1'b0, tsq_reg} + HALF_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cb_reg <= '0;
        else
            cb_reg <= ca_reg;
    end

    always_ff @(posedge clk)
    begin
        mt2_reg  <= mt2_sum[F +: TW];
        t2_reg   <= t2_sum[F +: TW];
        t_b_reg  <= t_a_reg;
        mt_b_reg <= mt_a_reg;
    end

    // ---------------- stage C: cubic terms ----------------
    csi_pkg::ctrl_t cc_reg;
    logic [P2W-1:0] pw0_reg;
    logic [P2W-1:0] pw1_reg;
    logic [P2W-1:0] pw2_reg;
    logic [P2W-1:0] pw3_reg;
    logic [TW-1:0]  t_c_reg;
    logic [TW-1:0]  mt_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cc_reg <= '0;
        else
            cc_reg <= cb_reg;
    end

    always_ff @(posedge clk)
    begin
        pw0_reg  <= mt2_reg * mt_b_reg;
        pw1_reg  <= mt2_reg * t_b_reg;
        pw2_reg  <= mt_b_reg * t2_reg;
        pw3_reg  <= t2_reg * t_b_reg;
        t_c_reg  <= t_b_reg;
        mt_c_reg <= mt_b_reg;
    end

    // ---------------- stage D: weights ----------------
    csi_pkg::ctrl_t cd_reg;
    logic [P2W:0]   w0_sum;
    logic [P2W:0]   w1_sum;
    logic [P2W:0]   w2_sum;
    logic [P2W:0]   w3_sum;
    logic [WW-1:0]  w0_next;
    logic [WW-1:0]  w1_next;
    logic [WW-1:0]  w2_next;
    logic [WW-1:0]  w3_next;
    logic [WW-1:0]  w0_reg;
    logic [WW-1:0]  w1_reg;
    logic [WW-1:0]  w2_reg;
    logic [WW-1:0]  w3_reg;

    assign w0_sum = {1'b0, pw0_reg} + HALF_P;
    assign w1_sum = {pw1_reg, 1'b0} + {1'b0, pw1_reg} + HALF_P;
    assign w2_sum = {pw2_reg, 1'b0} + {1'b0, pw2_reg} + HALF_P;
    assign w3_sum = {1'b0, pw3_reg} + HALF_P;

    always_comb
    begin
        if (cc_reg.line)
        begin
            w0_next = {1'b0, mt_c_reg};
            w1_next = '0;
            w2_next = '0;
            w3_next = {1'b0, t_c_reg};
        end
        else
        begin
            w0_next = w0_sum[F +: WW];
            w1_next = w1_sum[F +: WW];
            w2_next = w2_sum[F +: WW];
            w3_next = w3_sum[F +: WW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_reg <= '0;
        else
            cd_reg <= cc_reg;
    end

    always_ff @(posedge clk)
    begin
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        w3_reg <= w3_next;
    end

    // ---------------- stage E: blend products ----------------
    csi_pkg::ctrl_t     ce_reg;
    logic signed [PW-1:0] yp0_reg;
    logic signed [PW-1:0] yp1_reg;
    logic signed [PW-1:0] yp2_reg;
    logic signed [PW-1:0] yp3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ce_reg <= '0;
        else
            ce_reg <= cd_reg;
    end

    always_ff @(posedge clk)
    begin
        yp0_reg <= start_y_reg * $signed({1'b0, w0_reg});
        yp1_reg <= control_one_y_reg * $signed({1'b0, w1_reg});
        yp2_reg <= control_two_y_reg * $signed({1'b0, w2_reg});
        yp3_reg <= end_y_reg * $signed({1'b0, w3_reg});
    end

    // ---------------- stage F: pair sums ----------------
    csi_pkg::ctrl_t     cf_reg;
    logic signed [PW:0] s01_reg;
    logic signed [PW:0] s23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cf_reg <= '0;
        else
            cf_reg <= ce_reg;
    end

    always_ff @(posedge clk)
    begin
        s01_reg <= {yp0_reg[PW-1], yp0_reg} + {yp1_reg[PW-1], yp1_reg};
        s23_reg <= {yp2_reg[PW-1], yp2_reg} + {yp3_reg[PW-1], yp3_reg};
    end

    // ---------------- stage G: total plus rounding bias ----------------
    csi_pkg::ctrl_t       cg_reg;
    logic signed [AW-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cg_reg <= '0;
        else
            cg_reg <= cf_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= {s01_reg[PW], s01_reg} + {s23_reg[PW], s23_reg} + $signed(HALF_A);
    end

    // ---------------- output stage: shift, saturate, select ----------------
    csi_pkg::ctrl_t     cout_reg;
    logic [RW-1:0]      rnd_val;
    logic               in_range;
    logic signed [31:0] calc_val;
    logic signed [31:0] value_next;
    logic signed [31:0] value_reg;
    logic               clamped_reg;

    assign rnd_val  = acc_reg[AW-1:F];
    assign in_range = (&rnd_val[RW-1:31]) || !(|rnd_val[RW-1:31]);
    assign calc_val = in_range ? $signed(rnd_val[31:0])
                               : (rnd_val[RW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    always_comb
    begin
        case (cg_reg.sel)
            csi_pkg::RES_ZERO:  value_next = '0;
            csi_pkg::RES_START: value_next = start_y_reg;
            default:            value_next = calc_val;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cout_reg <= '0;
        else
            cout_reg <= cg_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        clamped_reg <= cg_reg.clamped;
    end

    assign done             = cout_reg.valid;
    assign sample_value     = value_reg;
    assign position_clamped = clamped_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT + 1))
        else $error("result without a matching accepted sample");

    a_clamp_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cdv_reg[0].valid && cdv_reg[0].clamped) |-> (cdv_reg[0].tsel != csi_pkg::T_DIV))
        else $error("clamped sample routed to divider");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cdv_reg[F].valid && (cdv_reg[F].tsel == csi_pkg::T_DIV))
            |-> (rem_reg[F] < dspan_reg[F]))
        else $error("divider remainder out of range");

    a_t_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ct_reg.valid |-> (({1'b0, t_reg} + {1'b0, mt_reg}) == {1'b0, ONE_T}))
        else $error("t and 1 - t disagree");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cg_reg.valid && (cg_reg.sel == csi_pkg::RES_ZERO))
            |=> (done && (sample_value == 32'sd0) && !position_clamped))
        else $error("move segment gave nonzero result");
`endif

endmodule

`default_nettype wire
